@@ rtl/rtpx_pkg.sv @@
// ----------------------------------------------------------------------------
// rtpx_pkg
// Shared types and constants for the RTP header check and sequence extender.
// ----------------------------------------------------------------------------
package rtpx_pkg;

   localparam logic [15:0] MAX_PACKET_BYTES = 16'd65535;
   localparam int          QUEUE_DEPTH      = 4;

   localparam logic [15:0] HDR_BYTES     = 16'd12;
   localparam logic [15:0] EXT_HDR_BYTES = 16'd16;
   localparam int          PAD_BIT       = 5;
   localparam int          EXT_BIT       = 4;
   localparam logic [1:0]  RTP_VERSION   = 2'd2;
   localparam logic [16:0] NO_SUSPECT    = 17'h10001;

   localparam logic [15:0] IDX_FIRST   = 16'd0;
   localparam logic [15:0] IDX_SEQ_HI  = 16'd2;
   localparam logic [15:0] IDX_SEQ_LO  = 16'd3;
   localparam logic [15:0] IDX_SSRC_0  = 16'd8;
   localparam logic [15:0] IDX_SSRC_1  = 16'd9;
   localparam logic [15:0] IDX_SSRC_2  = 16'd10;
   localparam logic [15:0] IDX_SSRC_3  = 16'd11;
   localparam logic [15:0] IDX_EXTW_HI = 16'd14;
   localparam logic [15:0] IDX_EXTW_LO = 16'd15;

   localparam logic [1:0] CSR_PROBATION_COUNT = 2'd0;
   localparam logic [1:0] CSR_MAX_DROPOUT     = 2'd1;
   localparam logic [1:0] CSR_MAX_MISORDER    = 2'd2;

   localparam logic [3:0]  PROBATION_RESET = 4'd2;
   localparam logic [15:0] DROPOUT_RESET   = 16'd3000;
   localparam logic [15:0] MISORDER_RESET  = 16'd100;

   typedef enum logic [2:0] {
      ST_ACCEPTED     = 3'd0,
      ST_TOO_SHORT    = 3'd1,
      ST_BAD_VERSION  = 3'd2,
      ST_PAD_OVERRUN  = 3'd3,
      ST_EXT_SHORT    = 3'd4,
      ST_EXT_OVERRUN  = 3'd5,
      ST_DROPPED_JUMP = 3'd6,
      ST_OVERSIZE     = 3'd7
   } rtpx_status_type;

   typedef struct packed {
      rtpx_status_type status;
      logic [15:0]     seq;
      logic [31:0]     src;
      logic [15:0]     off;
      logic [15:0]     plen;
   } rtpx_pkt_type;

   typedef struct packed {
      logic full;
      logic valid;
   } rtpx_qstat_type;

endpackage

@@ rtl/rtpx_ifs.sv @@
// ----------------------------------------------------------------------------
// rtpx_ifs
// Valid/ready channels for packet bytes in and per-packet status out.
// ----------------------------------------------------------------------------
interface rtpx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface rtpx_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] extended_seq;
   logic [31:0] source_id;
   logic [15:0] payload_offset;
   logic [15:0] payload_length;
   logic        on_probation;

   modport source (output valid, output status, output extended_seq, output source_id,
                   output payload_offset, output payload_length, output on_probation,
                   input ready);
   modport sink   (input valid, input status, input extended_seq, input source_id,
                   input payload_offset, input payload_length, input on_probation,
                   output ready);
endinterface

@@ rtl/rtpx_front.sv @@
// ----------------------------------------------------------------------------
// rtpx_front
// Byte counter, header capture and per-packet length/format classification.
// ----------------------------------------------------------------------------
module rtpx_front (
   input  logic               clock,
   input  logic               reset,
   rtpx_req_if.sink           req_bus,
   input  logic               q_full,
   output logic               push_valid,
   output rtpx_pkg::rtpx_pkt_type push_data
);

   logic [15:0] byte_count_ff, byte_count_in;
   logic        oversize_ff, oversize_in;
   logic [7:0]  hdr_ff, hdr_in;
   logic [15:0] seq_ff, seq_in;
   logic [31:0] src_ff, src_in;
   logic [15:0] extw_ff, extw_in;

   logic        pend_ff, pend_in;
   logic [15:0] ev_len_ff, ev_len_in;
   logic [7:0]  ev_pad_ff, ev_pad_in;
   logic [7:0]  ev_hdr_ff, ev_hdr_in;
   logic [15:0] ev_extw_ff, ev_extw_in;
   logic [15:0] ev_seq_ff, ev_seq_in;
   logic [31:0] ev_src_ff, ev_src_in;
   logic        ev_ovs_ff, ev_ovs_in;

   logic        accept, take_byte;
   logic [15:0] cnt_nx;
   logic        ovs_nx;
   logic [7:0]  b;

   logic [16:0] pad_diff;
   logic        pad_fail, has_pad, has_ext;
   logic [15:0] len_adj;
   logic [18:0] ext_need;
   logic [15:0] off;

   assign req_bus.ready = !pend_ff || !q_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.data_byte;
   assign take_byte     = !oversize_ff && (byte_count_ff != rtpx_pkg::MAX_PACKET_BYTES);

   always_comb begin
      cnt_nx  = byte_count_ff;
      ovs_nx  = oversize_ff;
      hdr_in  = hdr_ff;
      seq_in  = seq_ff;
      src_in  = src_ff;
      extw_in = extw_ff;
      if (accept) begin
         if (!take_byte) begin
            ovs_nx = 1'b1;
         end else begin
            cnt_nx = byte_count_ff + 16'd1;
            unique case (byte_count_ff)
               rtpx_pkg::IDX_FIRST:   hdr_in         = b;
               rtpx_pkg::IDX_SEQ_HI:  seq_in[15:8]   = b;
               rtpx_pkg::IDX_SEQ_LO:  seq_in[7:0]    = b;
               rtpx_pkg::IDX_SSRC_0:  src_in[31:24]  = b;
               rtpx_pkg::IDX_SSRC_1:  src_in[23:16]  = b;
               rtpx_pkg::IDX_SSRC_2:  src_in[15:8]   = b;
               rtpx_pkg::IDX_SSRC_3:  src_in[7:0]    = b;
               rtpx_pkg::IDX_EXTW_HI: extw_in[15:8]  = b;
               rtpx_pkg::IDX_EXTW_LO: extw_in[7:0]   = b;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      byte_count_in = cnt_nx;
      oversize_in   = ovs_nx;
      pend_in       = pend_ff && q_full;
      ev_len_in     = ev_len_ff;
      ev_pad_in     = ev_pad_ff;
      ev_hdr_in     = ev_hdr_ff;
      ev_extw_in    = ev_extw_ff;
      ev_seq_in     = ev_seq_ff;
      ev_src_in     = ev_src_ff;
      ev_ovs_in     = ev_ovs_ff;
      if (accept && req_bus.is_last) begin
         byte_count_in = 16'd0;
         oversize_in   = 1'b0;
         pend_in       = 1'b1;
         ev_len_in     = cnt_nx;
         ev_pad_in     = b;
         ev_hdr_in     = hdr_in;
         ev_extw_in    = extw_in;
         ev_seq_in     = seq_in;
         ev_src_in     = src_in;
         ev_ovs_in     = ovs_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 16'd0;
         oversize_ff   <= 1'b0;
         hdr_ff        <= 8'd0;
         seq_ff        <= 16'd0;
         src_ff        <= 32'd0;
         extw_ff       <= 16'd0;
         pend_ff       <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         oversize_ff   <= oversize_in;
         hdr_ff        <= hdr_in;
         seq_ff        <= seq_in;
         src_ff        <= src_in;
         extw_ff       <= extw_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_len_ff  <= ev_len_in;
      ev_pad_ff  <= ev_pad_in;
      ev_hdr_ff  <= ev_hdr_in;
      ev_extw_ff <= ev_extw_in;
      ev_seq_ff  <= ev_seq_in;
      ev_src_ff  <= ev_src_in;
      ev_ovs_ff  <= ev_ovs_in;
   end

   // classification of the pending packet
   assign has_pad  = ev_hdr_ff[rtpx_pkg::PAD_BIT];
   assign has_ext  = ev_hdr_ff[rtpx_pkg::EXT_BIT];
   assign pad_diff = {1'b0, ev_len_ff} - {9'd0, ev_pad_ff};
   assign pad_fail = has_pad && (pad_diff[16] || (pad_diff[15:0] < rtpx_pkg::HDR_BYTES));
   assign len_adj  = has_pad ? pad_diff[15:0] : ev_len_ff;
   assign ext_need = {1'b0, ev_extw_ff, 2'b00} + {3'd0, rtpx_pkg::EXT_HDR_BYTES};
   assign off      = has_ext ? ext_need[15:0] : rtpx_pkg::HDR_BYTES;

   always_comb begin
      priority if (ev_ovs_ff) begin
         push_data.status = rtpx_pkg::ST_OVERSIZE;
      end else if (ev_len_ff < rtpx_pkg::HDR_BYTES) begin
         push_data.status = rtpx_pkg::ST_TOO_SHORT;
      end else if (ev_hdr_ff[7:6] != rtpx_pkg::RTP_VERSION) begin
         push_data.status = rtpx_pkg::ST_BAD_VERSION;
      end else if (pad_fail) begin
         push_data.status = rtpx_pkg::ST_PAD_OVERRUN;
      end else if (has_ext && (len_adj < rtpx_pkg::EXT_HDR_BYTES)) begin
         push_data.status = rtpx_pkg::ST_EXT_SHORT;
      end else if (has_ext && ({3'd0, len_adj} < ext_need)) begin
         push_data.status = rtpx_pkg::ST_EXT_OVERRUN;
      end else begin
         push_data.status = rtpx_pkg::ST_ACCEPTED;
      end
      push_data.seq  = ev_seq_ff;
      push_data.src  = ev_src_ff;
      push_data.off  = off;
      push_data.plen = len_adj - off;
   end

   assign push_valid = pend_ff;

endmodule

@@ rtl/rtpx_queue.sv @@
// ----------------------------------------------------------------------------
// rtpx_queue
// Short FIFO of classified packets between the front and the tracker.
// ----------------------------------------------------------------------------
module rtpx_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  rtpx_pkg::rtpx_pkt_type    push_data,
   input  logic                      pop,
   output rtpx_pkg::rtpx_qstat_type  qstat,
   output rtpx_pkg::rtpx_pkt_type    pop_data
);

   localparam int PTR_W = $clog2(rtpx_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(rtpx_pkg::QUEUE_DEPTH + 1);

   rtpx_pkg::rtpx_pkt_type mem [rtpx_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign qstat.full  = (count_ff == CNT_W'(rtpx_pkg::QUEUE_DEPTH));
   assign qstat.valid = (count_ff != '0);
   assign do_push     = push_valid && !qstat.full;
   assign do_pop      = pop && qstat.valid;
   assign pop_data    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(rtpx_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(rtpx_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/rtpx_back.sv @@
// ----------------------------------------------------------------------------
// rtpx_back
// Sequence tracker (probation, wrap count, jump drop/resync), config
// registers and the registered status output.
// ----------------------------------------------------------------------------
module rtpx_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata,
   input  logic                   q_valid,
   input  rtpx_pkg::rtpx_pkt_type q_data,
   output logic                   pop,
   rtpx_rsp_if.source             rsp_bus
);

   logic [3:0]  prob_count_ff, prob_count_in;
   logic [15:0] max_drop_ff, max_drop_in;
   logic [15:0] max_mis_ff, max_mis_in;

   logic [15:0] highest_ff, highest_in;
   logic [15:0] wrap_ff, wrap_in;
   logic [16:0] suspect_ff, suspect_in;
   logic [3:0]  prob_left_ff, prob_left_in;
   logic        started_ff, started_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rtpx_pkg::rtpx_status_type status_ff, status_in;
   logic [31:0] ext_ff, ext_in;
   logic [31:0] src_ff, src_in;
   logic [15:0] off_ff, off_in;
   logic [15:0] plen_ff, plen_in;
   logic        probe_ff, probe_in;

   logic [15:0] seq, udelta;
   logic [16:0] jump_limit;
   logic        in_order, in_jump;

   always_comb begin
      prob_count_in = prob_count_ff;
      max_drop_in   = max_drop_ff;
      max_mis_in    = max_mis_ff;
      if (csr_we) begin
         unique case (csr_index)
            rtpx_pkg::CSR_PROBATION_COUNT: prob_count_in = csr_wdata[3:0];
            rtpx_pkg::CSR_MAX_DROPOUT:     max_drop_in   = csr_wdata;
            rtpx_pkg::CSR_MAX_MISORDER:    max_mis_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   assign pop        = q_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign seq        = q_data.seq;
   assign udelta     = seq - highest_ff;
   assign jump_limit = 17'h10000 - {1'b0, max_mis_ff};
   assign in_order   = udelta < max_drop_ff;
   assign in_jump    = {1'b0, udelta} <= jump_limit;

   always_comb begin
      highest_in   = highest_ff;
      wrap_in      = wrap_ff;
      suspect_in   = suspect_ff;
      prob_left_in = prob_left_ff;
      started_in   = started_ff;
      status_in    = q_data.status;
      src_in       = q_data.src;
      off_in       = q_data.off;
      plen_in      = q_data.plen;
      ext_in       = 32'd0;
      probe_in     = 1'b0;
      if (q_data.status != rtpx_pkg::ST_ACCEPTED) begin
         src_in  = 32'd0;
         off_in  = 16'd0;
         plen_in = 16'd0;
      end else begin
         probe_in = (prob_left_ff != 4'd0);
         priority if (!started_ff) begin
            highest_in = seq - 16'd1;
            wrap_in    = 16'd0;
            suspect_in = rtpx_pkg::NO_SUSPECT;
            started_in = 1'b1;
            ext_in     = {16'd0, seq};
         end else if (prob_left_ff != 4'd0) begin
            ext_in     = {wrap_ff, seq};
            highest_in = seq;
            if (seq == highest_ff + 16'd1) begin
               prob_left_in = prob_left_ff - 4'd1;
               if (prob_left_ff == 4'd1) begin
                  wrap_in    = 16'd0;
                  suspect_in = rtpx_pkg::NO_SUSPECT;
               end
            end else begin
               prob_left_in = (prob_count_ff == 4'd0) ? 4'd0 : prob_count_ff - 4'd1;
            end
         end else if (in_order) begin
            if (seq < highest_ff) begin
               wrap_in = wrap_ff + 16'd1;
            end
            highest_in = seq;
            ext_in     = {wrap_in, seq};
         end else if (in_jump) begin
            if ({1'b0, seq} == suspect_ff) begin
               highest_in = seq;
               wrap_in    = 16'd0;
               suspect_in = rtpx_pkg::NO_SUSPECT;
               ext_in     = {16'd0, seq};
            end else begin
               suspect_in = {1'b0, seq + 16'd1};
               status_in  = rtpx_pkg::ST_DROPPED_JUMP;
               probe_in   = 1'b0;
            end
         end else begin
            ext_in = {wrap_ff, seq};
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prob_count_ff <= rtpx_pkg::PROBATION_RESET;
         max_drop_ff   <= rtpx_pkg::DROPOUT_RESET;
         max_mis_ff    <= rtpx_pkg::MISORDER_RESET;
         highest_ff    <= 16'd0;
         wrap_ff       <= 16'd0;
         suspect_ff    <= rtpx_pkg::NO_SUSPECT;
         prob_left_ff  <= rtpx_pkg::PROBATION_RESET;
         started_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prob_count_ff <= prob_count_in;
         max_drop_ff   <= max_drop_in;
         max_mis_ff    <= max_mis_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (pop) begin
            highest_ff   <= highest_in;
            wrap_ff      <= wrap_in;
            suspect_ff   <= suspect_in;
            prob_left_ff <= prob_left_in;
            started_ff   <= started_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         ext_ff    <= ext_in;
         src_ff    <= src_in;
         off_ff    <= off_in;
         plen_ff   <= plen_in;
         probe_ff  <= probe_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.extended_seq   = ext_ff;
   assign rsp_bus.source_id      = src_ff;
   assign rsp_bus.payload_offset = off_ff;
   assign rsp_bus.payload_length = plen_ff;
   assign rsp_bus.on_probation   = probe_ff;

endmodule

@@ rtl/rtp_header_check_seq_extend_core.sv @@
// ----------------------------------------------------------------------------
// rtp_header_check_seq_extend_core
// RTP header checker and 32-bit sequence number extender.
//
// req_bus carries one packet byte per request; is_last marks the final byte.
// rsp_bus returns one status per packet: format checks, payload offset and
// length, SSRC, extended sequence number and probation flag.
// csr_we/csr_index/csr_wdata write probation count (0), max dropout (1) and
// max misorder (2); write only while no packet is in flight.
// Throughput: one byte per cycle while the queue has room, including short
// back-to-back packets; the tracker finishes one packet per cycle while
// rsp_bus is ready. A status passes the capture register, a queue entry and
// the tracker output register; a full queue or rsp stall can hold it between.
// Rsp stall: the output register holds, packets collect in a 4-entry queue,
// and req_bus.ready drops only once that queue is full and a finished packet
// is still waiting in the front.
// Reset: counters, tracker and config return to their defaults; no result.
// ----------------------------------------------------------------------------
module rtp_header_check_seq_extend_core (
   input  logic        clock,
   input  logic        reset,
   rtpx_req_if.sink    req_bus,
   rtpx_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic                      push_valid;
   rtpx_pkg::rtpx_pkt_type    push_data;
   rtpx_pkg::rtpx_pkt_type    q_data;
   rtpx_pkg::rtpx_qstat_type  qstat;
   logic                      pop;

   rtpx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .q_full     (qstat.full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   rtpx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .qstat      (qstat),
      .pop_data   (q_data)
   );

   rtpx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (qstat.valid),
      .q_data     (q_data),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("response valid after reset");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> qstat.full)
      else $error("request stalled with queue space");

   a_full_valid: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> qstat.valid)
      else $error("queue full but empty");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (qstat.valid && !rsp_bus.valid) |=> rsp_bus.valid)
      else $error("queued packet not moved to output");

endmodule

@@ tb/sv/rtpx_status_monitor.sv @@
// ----------------------------------------------------------------------------
// rtpx_status_monitor
// Watches the byte requests, the CSR port and the status channel of the RTP
// header checker. It tracks the header capture and the sequence tracker in
// its own state, queues the status each final byte must produce, and checks
// every returned status field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module rtpx_status_monitor
   import rtpx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rtpx_req_if         req_mon,
   rtpx_rsp_if         rsp_mon,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      rtpx_status_type status;
      logic [31:0]     ext_seq;
      logic [31:0]     ssrc;
      logic [15:0]     offset;
      logic [15:0]     length;
      logic            probation;
   } pkt_verdict_type;

   pkt_verdict_type expected_status_q[$];

   logic [3:0]  cfg_probation;
   logic [15:0] cfg_dropout;
   logic [15:0] cfg_misorder;

   int          byte_cnt;
   bit          too_big;
   logic [7:0]  first_byte;
   logic [15:0] cap_seq;
   logic [31:0] cap_ssrc;
   logic [15:0] cap_ext_words;
   logic [15:0] top_seq;
   logic [15:0] wraps;
   logic [16:0] suspect;
   logic [3:0]  probation_left;
   bit          started;

   function automatic void restore_defaults();
      cfg_probation  = PROBATION_RESET;
      cfg_dropout    = DROPOUT_RESET;
      cfg_misorder   = MISORDER_RESET;
      byte_cnt       = 0;
      too_big        = 1'b0;
      first_byte     = '0;
      cap_seq        = '0;
      cap_ssrc       = '0;
      cap_ext_words  = '0;
      top_seq        = '0;
      wraps          = '0;
      suspect        = NO_SUSPECT;
      probation_left = PROBATION_RESET;
      started        = 1'b0;
   endfunction

   function automatic rtpx_status_type extend_sequence(input logic [15:0] seq,
                                                       output logic [31:0] ext,
                                                       output logic probe);
      logic [15:0] delta;
      probe = (probation_left != 4'd0);
      ext   = {wraps, seq};
      if (!started) begin
         top_seq = seq - 16'd1;
         wraps   = '0;
         suspect = NO_SUSPECT;
         started = 1'b1;
         ext     = {16'd0, seq};
         return ST_ACCEPTED;
      end
      if (probation_left != 4'd0) begin
         if (seq == top_seq + 16'd1) begin
            probation_left = probation_left - 4'd1;
            top_seq        = seq;
            if (probation_left == 4'd0) begin
               wraps   = '0;
               suspect = NO_SUSPECT;
            end
         end else begin
            probation_left = (cfg_probation == 4'd0) ? 4'd0 : cfg_probation - 4'd1;
            top_seq        = seq;
         end
         return ST_ACCEPTED;
      end
      delta = seq - top_seq;
      if (delta < cfg_dropout) begin
         if (seq < top_seq)
            wraps = wraps + 16'd1;
         top_seq = seq;
      end else if ({16'd0, delta} <= 32'd65536 - {16'd0, cfg_misorder}) begin
         if ({1'b0, seq} == suspect) begin
            top_seq = seq;
            wraps   = '0;
            suspect = NO_SUSPECT;
         end else begin
            suspect = {1'b0, seq + 16'd1};
            ext     = '0;
            probe   = 1'b0;
            return ST_DROPPED_JUMP;
         end
      end
      ext = {wraps, seq};
      return ST_ACCEPTED;
   endfunction

   // Returns 1 when the byte closes a packet; res then holds its status.
   function automatic bit absorb_byte(input logic [7:0] b, input logic last,
                                      output pkt_verdict_type res);
      int          len;
      int          off;
      int          ext_len;
      logic [31:0] ext;
      logic        probe;
      res = '0;
      if (too_big || byte_cnt >= int'(MAX_PACKET_BYTES)) begin
         too_big = 1'b1;
      end else begin
         case (byte_cnt)
            IDX_FIRST:   first_byte          = b;
            IDX_SEQ_HI:  cap_seq[15:8]       = b;
            IDX_SEQ_LO:  cap_seq[7:0]        = b;
            IDX_SSRC_0:  cap_ssrc[31:24]     = b;
            IDX_SSRC_1:  cap_ssrc[23:16]     = b;
            IDX_SSRC_2:  cap_ssrc[15:8]      = b;
            IDX_SSRC_3:  cap_ssrc[7:0]       = b;
            IDX_EXTW_HI: cap_ext_words[15:8] = b;
            IDX_EXTW_LO: cap_ext_words[7:0]  = b;
            default: ;
         endcase
         byte_cnt++;
      end
      if (!last)
         return 1'b0;

      len        = byte_cnt;
      res.status = ST_ACCEPTED;
      if (too_big) begin
         res.status = ST_OVERSIZE;
      end else if (len < int'(HDR_BYTES)) begin
         res.status = ST_TOO_SHORT;
      end else if (first_byte[7:6] != RTP_VERSION) begin
         res.status = ST_BAD_VERSION;
      end else begin
         off = int'(HDR_BYTES);
         if (first_byte[PAD_BIT]) begin
            if (int'(b) + int'(HDR_BYTES) > len)
               res.status = ST_PAD_OVERRUN;
            else
               len -= int'(b);
         end
         if (res.status == ST_ACCEPTED && first_byte[EXT_BIT]) begin
            ext_len = 4 * int'(cap_ext_words);
            if (len < off + 4)
               res.status = ST_EXT_SHORT;
            else if (len < off + 4 + ext_len)
               res.status = ST_EXT_OVERRUN;
            else
               off += 4 + ext_len;
         end
         if (res.status == ST_ACCEPTED) begin
            res.status    = extend_sequence(cap_seq, ext, probe);
            res.ext_seq   = ext;
            res.probation = probe;
            res.ssrc      = cap_ssrc;
            res.offset    = 16'(off);
            res.length    = 16'(len - off);
         end
      end
      if (res.status != ST_ACCEPTED && res.status != ST_DROPPED_JUMP) begin
         res.ext_seq   = '0;
         res.ssrc      = '0;
         res.offset    = '0;
         res.length    = '0;
         res.probation = 1'b0;
      end
      byte_cnt = 0;
      too_big  = 1'b0;
      return 1'b1;
   endfunction

   function automatic int check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      pkt_verdict_type want;
      int              errs;
      errs = 0;
      if (reset) begin
         restore_defaults();
         expected_status_q.delete();
         pending    <= 0;
         fail_count <= 0;
         checked    <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PROBATION_COUNT: cfg_probation = csr_wdata[3:0];
               CSR_MAX_DROPOUT:     cfg_dropout   = csr_wdata;
               CSR_MAX_MISORDER:    cfg_misorder  = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready &&
             absorb_byte(req_mon.data_byte, req_mon.is_last, want))
            expected_status_q.push_back(want);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_status_q.size() == 0) begin
               $error("status returned with no packet outstanding");
               errs++;
            end else begin
               want = expected_status_q.pop_front();
               errs += check_field("status", 32'(want.status), 32'(rsp_mon.status));
               errs += check_field("extended_seq", want.ext_seq, rsp_mon.extended_seq);
               errs += check_field("source_id", want.ssrc, rsp_mon.source_id);
               errs += check_field("payload_offset", 32'(want.offset),
                                   32'(rsp_mon.payload_offset));
               errs += check_field("payload_length", 32'(want.length),
                                   32'(rsp_mon.payload_length));
               errs += check_field("on_probation", 32'(want.probation),
                                   32'(rsp_mon.on_probation));
               checked <= checked + 1;
            end
         end
         fail_count <= fail_count + errs;
         pending    <= expected_status_q.size();
      end
   end

endmodule

@@ tb/sv/tb_rtp_header_check_seq_extend_core.sv @@
// ----------------------------------------------------------------------------
// tb_rtp_header_check_seq_extend_core
// Feeds RTP packets byte by byte into the header checker: directed packets for
// every status, the probation and wrap corners, the largest legal packet and
// an oversize one, then random packet streams under four register settings
// with sender gaps and status backpressure. Checking lives in the monitor.
// ----------------------------------------------------------------------------
module tb_rtp_header_check_seq_extend_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rtpx_pkg::*;

   localparam int         HALF_PERIOD  = 5;
   localparam int         RESET_CYCLES = 8;
   localparam int         DRAIN_CYCLES = 4;
   localparam int         TIMEOUT_NS   = 6_000_000;
   localparam int         MAX_BODY     = int'(MAX_PACKET_BYTES) - int'(HDR_BYTES);
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   int          fail_count;
   int          pending;
   int          checked;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          packets_sent  = 0;
   int          bytes_sent    = 0;
   int          settings_used = 0;
   logic [15:0] next_seq;
   logic [7:0]  frame[$];

   rtpx_req_if req_bus();
   rtpx_rsp_if rsp_bus();

   rtp_header_check_seq_extend_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rtpx_status_monitor monitor (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #TIMEOUT_NS;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= value;
      req_bus.is_last   <= last;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame[i])
         send_byte(frame[i], i == frame.size() - 1);
      packets_sent++;
   endtask

   function automatic void build_frame(input logic [1:0] version, input bit pad, input bit ext,
                                       input logic [15:0] seq, input logic [31:0] ssrc,
                                       input int ext_words, input int ext_sent,
                                       input int body_len, input int pad_len);
      frame.delete();
      frame.push_back({version, pad, ext, 4'($urandom)});
      frame.push_back(8'($urandom));
      frame.push_back(seq[15:8]);
      frame.push_back(seq[7:0]);
      repeat (4) frame.push_back(8'($urandom));
      frame.push_back(ssrc[31:24]);
      frame.push_back(ssrc[23:16]);
      frame.push_back(ssrc[15:8]);
      frame.push_back(ssrc[7:0]);
      if (ext) begin
         frame.push_back(8'($urandom));
         frame.push_back(8'($urandom));
         frame.push_back(ext_words[15:8]);
         frame.push_back(ext_words[7:0]);
         repeat (4 * ext_sent) frame.push_back(8'($urandom));
      end
      repeat (body_len) frame.push_back(8'($urandom));
      if (pad_len > 0) begin
         repeat (pad_len - 1) frame.push_back(8'h00);
         frame.push_back(8'(pad_len));
      end
   endfunction

   function automatic void cut_frame(input int keep);
      if (keep < frame.size())
         frame = frame[0:keep-1];
   endfunction

   task automatic apply_settings(input logic [3:0] probation, input logic [15:0] dropout,
                                 input logic [15:0] misorder);
      csr_we    <= 1'b1;
      csr_index <= CSR_PROBATION_COUNT;
      csr_wdata <= {12'd0, probation};
      @(posedge clock);
      csr_index <= CSR_MAX_DROPOUT;
      csr_wdata <= dropout;
      @(posedge clock);
      csr_index <= CSR_MAX_MISORDER;
      csr_wdata <= misorder;
      @(posedge clock);
      // unmapped index, must be ignored
      csr_index <= CSR_UNMAPPED;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_packet();
      int          roll;
      int          body;
      int          words;
      int          sent;
      int          padn;
      logic [15:0] seq;
      bit          pad;
      bit          ext;
      roll = $urandom_range(99);
      if (roll < 60) begin
         seq = next_seq;
      end else if (roll < 70) begin
         seq = next_seq + 16'($urandom_range(1, 40));
      end else if (roll < 82) begin
         seq = next_seq - 16'($urandom_range(1, 150));
      end else if (roll < 92) begin
         seq = 16'($urandom);
      end else begin
         seq = 16'hFFF0 + 16'($urandom_range(0, 15));
      end
      if (roll < 70 || roll >= 82)
         next_seq = seq + 16'd1;

      pad   = ($urandom_range(3) == 0);
      ext   = ($urandom_range(9) < 3);
      words = $urandom_range(3);
      body  = $urandom_range(12);
      padn  = pad ? $urandom_range(1, 8) : 0;
      roll  = $urandom_range(99);
      if (roll < 70) begin
         build_frame(RTP_VERSION, pad, ext, seq, $urandom, words, words, body, padn);
      end else if (roll < 75) begin
         build_frame(RTP_VERSION + 2'($urandom_range(1, 3)), pad, ext, seq, $urandom,
                     words, words, body, padn);
      end else if (roll < 79) begin
         build_frame(RTP_VERSION, pad, ext, seq, $urandom, words, words, body, padn);
         cut_frame($urandom_range(1, int'(HDR_BYTES) - 1));
      end else if (roll < 83) begin
         build_frame(RTP_VERSION, 1'b1, ext, seq, $urandom, words, words, body, 1);
         frame[frame.size()-1] = 8'($urandom_range(frame.size() - 11, 255));
      end else if (roll < 87) begin
         build_frame(RTP_VERSION, 1'b0, 1'b1, seq, $urandom, words, words, body, 0);
         cut_frame($urandom_range(int'(HDR_BYTES), int'(HDR_BYTES) + 3));
      end else if (roll < 91) begin
         words = $urandom_range(1, 65535);
         sent  = $urandom_range(0, (words > 3) ? 3 : words - 1);
         build_frame(RTP_VERSION, 1'b0, 1'b1, seq, $urandom, words, sent,
                     $urandom_range(3), 0);
      end else if (roll < 96) begin
         frame.delete();
         repeat ($urandom_range(1, 30)) frame.push_back(8'($urandom));
      end else begin
         // padding that exactly eats everything after the fixed header
         build_frame(RTP_VERSION, 1'b1, ext, seq, $urandom, words, words, body, 1);
         frame[frame.size()-1] = 8'(frame.size() - int'(HDR_BYTES));
      end
      send_frame();
   endtask

   task automatic run_phase(input int idle, input int stall, input int min_bytes,
                            input int min_packets);
      int bytes_at_start;
      int packets_at_start;
      send_idle_pct    = idle;
      stall_pct        = stall;
      bytes_at_start   = bytes_sent;
      packets_at_start = packets_sent;
      while (bytes_sent - bytes_at_start < min_bytes ||
             packets_sent - packets_at_start < min_packets)
         random_packet();
      settle();
   endtask

   initial begin
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_PROBATION_COUNT;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.is_last   <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // probation already running at 2 must not pick up the new count
      apply_settings(4'd15, DROPOUT_RESET, MISORDER_RESET);

      frame.delete();
      frame.push_back(8'hFF);
      send_frame();
      build_frame(RTP_VERSION, 1'b0, 1'b0, 16'h1234, 32'h0, 0, 0, 0, 0);
      cut_frame(int'(HDR_BYTES) - 1);
      send_frame();
      build_frame(2'd0, 1'b0, 1'b0, 16'h1234, 32'h0, 0, 0, 4, 0);
      send_frame();
      build_frame(RTP_VERSION + 2'd1, 1'b1, 1'b1, 16'h1234, 32'h0, 0, 0, 0, 0);
      send_frame();
      build_frame(RTP_VERSION, 1'b1, 1'b0, 16'h1234, 32'h0, 0, 0, 6, 1);
      frame[frame.size()-1] = 8'hFF;
      send_frame();
      build_frame(RTP_VERSION, 1'b0, 1'b1, 16'h1234, 32'h0, 0, 0, 0, 0);
      cut_frame(int'(HDR_BYTES) + 2);
      send_frame();
      build_frame(RTP_VERSION, 1'b0, 1'b1, 16'h1234, 32'h0, 16'hFFFF, 1, 0, 0);
      send_frame();

      // tracker start at the top of the sequence space, then in order across 0
      build_frame(RTP_VERSION, 1'b0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
      send_frame();
      build_frame(RTP_VERSION, 1'b0, 1'b0, 16'h0000, 32'hFFFF_FFFF, 0, 0, 3, 0);
      send_frame();
      build_frame(RTP_VERSION, 1'b0, 1'b0, 16'd5, 32'hFFFF_FFFF, 0, 0, 3, 0);
      send_frame();
      for (int s = 6; s <= 19; s++) begin
         build_frame(RTP_VERSION, 1'b0, 1'b0, 16'(s), 32'h0000_0001, 0, 0, 1, 0);
         send_frame();
      end
      build_frame(RTP_VERSION, 1'b1, 1'b1, 16'd20, 32'hA5A5_5A5A, 1, 1, 5, 3);
      send_frame();
      build_frame(RTP_VERSION, 1'b1, 1'b0, 16'd21, 32'hA5A5_5A5A, 0, 0, 0, 10);
      send_frame();
      // large jump dropped, then its successor re-syncs, then a reordered one
      build_frame(RTP_VERSION, 1'b0, 1'b0, 16'd5022, 32'h0, 0, 0, 2, 0);
      send_frame();
      build_frame(RTP_VERSION, 1'b0, 1'b0, 16'd5023, 32'h0, 0, 0, 2, 0);
      send_frame();
      build_frame(RTP_VERSION, 1'b0, 1'b0, 16'd5000, 32'h0, 0, 0, 2, 0);
      send_frame();
      // largest legal packet, then one byte more
      build_frame(RTP_VERSION, 1'b0, 1'b0, 16'd5024, 32'h1357_9BDF, 0, 0, MAX_BODY, 0);
      send_frame();
      build_frame(RTP_VERSION, 1'b0, 1'b0, 16'd5025, 32'h1357_9BDF, 0, 0, MAX_BODY + 1, 0);
      send_frame();
      frame.delete();
      settle();

      next_seq = 16'd5025;
      run_phase(0, 0, 150, 12);
      apply_settings(4'd1, 16'd1, 16'd65535);
      run_phase(78, 0, 150, 12);
      apply_settings(4'd7, 16'd65535, 16'd0);
      run_phase(0, 78, 150, 12);
      apply_settings(4'd2, 16'd500, 16'd300);
      run_phase(16, 16, 150, 12);

      $display("Run covered %0d packets (%0d bytes) under %0d register settings,",
               packets_sent, bytes_sent, settings_used);
      $display("all statuses, maximum-length and oversize packets; %0d statuses compared.",
               checked);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ files.f @@
rtl/rtpx_pkg.sv
rtl/rtpx_ifs.sv
rtl/rtpx_front.sv
rtl/rtpx_queue.sv
rtl/rtpx_back.sv
rtl/rtp_header_check_seq_extend_core.sv
tb/sv/rtpx_status_monitor.sv
tb/sv/tb_rtp_header_check_seq_extend_core.sv
